>>> design/ede_pkg.sv
package ede_pkg;

   localparam int MAX_LEN     = 64;
   localparam int SYMBOL_BITS = 8;
   localparam int LEN_BITS    = $clog2(MAX_LEN + 1);
   localparam int IDX_BITS    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DIST_BITS   = 7;
   localparam int SYM_IN_BITS = 8;
   localparam int OP_BITS     = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_APPEND_A = 2'd0,
      OP_APPEND_B = 2'd1,
      OP_COMPUTE  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      STEP_IDLE      = 4'd0,
      STEP_INIT      = 4'd1,
      STEP_INIT_LOOP = 4'd2,
      STEP_ROW_START = 4'd3,
      STEP_ROW_INIT  = 4'd4,
      STEP_CELL_READ = 4'd5,
      STEP_CELL_CALC = 4'd6,
      STEP_FIN_READ  = 4'd7,
      STEP_EMIT      = 4'd8
   } step_type;

   // stay: repeat this step until j reaches lb
   // back: return to the previous step until j reaches lb
   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_DISPATCH,
      JMP_I_END,
      JMP_J_STAY,
      JMP_J_BACK,
      JMP_LB_ZERO
   } jump_type;

   typedef enum logic [1:0] {
      J_HOLD,
      J_ZERO,
      J_ONE,
      J_INC
   } j_op_type;

   typedef enum logic [1:0] {
      I_HOLD,
      I_ZERO,
      I_INC
   } i_op_type;

   typedef enum logic [1:0] {
      COST_WR_NONE,
      COST_WR_J,
      COST_WR_ROW,
      COST_WR_CELL
   } cost_wr_type;

   typedef enum logic [1:0] {
      COST_RD_ZERO,
      COST_RD_J,
      COST_RD_LB
   } cost_rd_type;

   typedef struct packed {
      logic        busy;
      jump_type    jump;
      step_type    target;
      j_op_type    j_op;
      i_op_type    i_op;
      cost_wr_type cost_wr;
      cost_rd_type cost_rd;
      logic        row_load;
      logic        calc;
      logic        emit;
   } ctrl_type;

   typedef struct packed {
      logic i_end;
      logic j_end;
      logic lb_zero;
   } cond_type;

   function automatic ctrl_type microcode(step_type step);
      ctrl_type w;
      w = '0;
      case (step)
         STEP_IDLE: begin
            w.jump   = JMP_DISPATCH;
            w.target = STEP_INIT;
         end
         STEP_INIT: begin
            w.busy = 1'b1;
            w.j_op = J_ZERO;
            w.i_op = I_ZERO;
         end
         STEP_INIT_LOOP: begin
            w.busy    = 1'b1;
            w.jump    = JMP_J_STAY;
            w.target  = STEP_ROW_START;
            w.j_op    = J_INC;
            w.cost_wr = COST_WR_J;
         end
         STEP_ROW_START: begin
            w.busy    = 1'b1;
            w.jump    = JMP_I_END;
            w.target  = STEP_FIN_READ;
            w.cost_rd = COST_RD_ZERO;
         end
         STEP_ROW_INIT: begin
            w.busy     = 1'b1;
            w.jump     = JMP_LB_ZERO;
            w.target   = STEP_ROW_START;
            w.j_op     = J_ONE;
            w.i_op     = I_INC;
            w.cost_wr  = COST_WR_ROW;
            w.row_load = 1'b1;
         end
         STEP_CELL_READ: begin
            w.busy    = 1'b1;
            w.cost_rd = COST_RD_J;
         end
         STEP_CELL_CALC: begin
            w.busy    = 1'b1;
            w.jump    = JMP_J_BACK;
            w.target  = STEP_ROW_START;
            w.j_op    = J_INC;
            w.cost_wr = COST_WR_CELL;
            w.calc    = 1'b1;
         end
         STEP_FIN_READ: begin
            w.busy    = 1'b1;
            w.cost_rd = COST_RD_LB;
         end
         STEP_EMIT: begin
            w.busy   = 1'b1;
            w.jump   = JMP_ALWAYS;
            w.target = STEP_IDLE;
            w.emit   = 1'b1;
         end
         default: begin
            w.jump   = JMP_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> design/edit_distance_engine_top.sv
// append transfer: taken only while busy is low, busy stays low, one transfer per cycle while busy is low
// compute transfer: rsp_valid strobes once the microcode has walked the cost row for every symbol of string a
// busy falls the cycle after the strobe
// each table cell takes a registered read of the cost row, then the cell update
// reset clears lengths, overflow flag and the step counter; string and row memories are not cleared
module edit_distance_engine_top
   import ede_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic [SYM_IN_BITS-1:0] req_symbol,
   output logic                   rsp_valid,
   output logic [DIST_BITS-1:0]   rsp_distance,
   output logic                   rsp_overflow
);

   ctrl_type ctrl;
   cond_type cond;

   ede_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .cond          (cond),
      .ctrl          (ctrl)
   );

   ede_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .req_symbol    (req_symbol),
      .ctrl          (ctrl),
      .cond          (cond),
      .rsp_distance  (rsp_distance),
      .rsp_overflow  (rsp_overflow)
   );

   assign busy      = ctrl.busy;
   assign rsp_valid = ctrl.emit;

endmodule

>>> design/ede_ram.sv
module ede_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ede_sequencer.sv
module ede_sequencer
   import ede_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OP_BITS-1:0]  req_operation,
   input  cond_type            cond,
   output ctrl_type            ctrl
);

   step_type step_ff;
   step_type step_in;
   step_type step_next;
   step_type step_back;

   assign step_next = step_type'(step_ff + 4'd1);
   assign step_back = step_type'(step_ff - 4'd1);

   always_comb begin
      ctrl = microcode(step_ff);
   end

   always_comb begin
      case (ctrl.jump)
         JMP_NEXT:     step_in = step_next;
         JMP_ALWAYS:   step_in = ctrl.target;
         JMP_DISPATCH: step_in = (start && (req_operation == OP_COMPUTE)) ? ctrl.target : step_ff;
         JMP_I_END:    step_in = cond.i_end ? ctrl.target : step_next;
         JMP_J_STAY:   step_in = cond.j_end ? ctrl.target : step_ff;
         JMP_J_BACK:   step_in = cond.j_end ? ctrl.target : step_back;
         JMP_LB_ZERO:  step_in = cond.lb_zero ? ctrl.target : step_next;
         default:      step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> design/ede_datapath.sv
module ede_datapath
   import ede_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic [SYM_IN_BITS-1:0] req_symbol,
   input  ctrl_type               ctrl,
   output cond_type               cond,
   output logic [DIST_BITS-1:0]   rsp_distance,
   output logic                   rsp_overflow
);

   logic [LEN_BITS-1:0]    len_a_ff, len_a_in;
   logic [LEN_BITS-1:0]    len_b_ff, len_b_in;
   logic                   ovf_ff, ovf_in;
   logic [LEN_BITS-1:0]    i_ff, i_in;
   logic [LEN_BITS-1:0]    j_ff, j_in;
   logic [LEN_BITS-1:0]    diag_ff, diag_in;
   logic [LEN_BITS-1:0]    left_ff, left_in;
   logic [SYMBOL_BITS-1:0] a_sym_ff, a_sym_in;

   logic                   take;
   logic                   append_a;
   logic                   append_b;
   logic                   full_a;
   logic                   full_b;
   logic [SYMBOL_BITS-1:0] sym;
   logic [SYMBOL_BITS-1:0] a_rd;
   logic [SYMBOL_BITS-1:0] b_rd;
   logic [LEN_BITS-1:0]    cost_rd;
   logic [LEN_BITS-1:0]    j_minus_one;
   logic                   cost_wr_en;
   logic [LEN_BITS-1:0]    cost_wr_addr;
   logic [LEN_BITS-1:0]    cost_wr_data;
   logic [LEN_BITS-1:0]    cost_rd_addr;
   logic [LEN_BITS-1:0]    min_da;
   logic [LEN_BITS-1:0]    min_all;
   logic [LEN_BITS-1:0]    cell_value;
   logic [LEN_BITS-1:0]    i_plus_one;

   assign take     = start && !ctrl.busy;
   assign append_a = take && (req_operation == OP_APPEND_A);
   assign append_b = take && (req_operation == OP_APPEND_B);
   assign full_a   = (len_a_ff == LEN_BITS'(MAX_LEN));
   assign full_b   = (len_b_ff == LEN_BITS'(MAX_LEN));
   assign sym      = SYMBOL_BITS'(req_symbol);

   assign j_minus_one = j_ff - LEN_BITS'(1);
   assign i_plus_one  = i_ff + LEN_BITS'(1);

   ede_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_ram_a (
      .clock   (clock),
      .wr_en   (append_a && !full_a),
      .wr_addr (len_a_ff[IDX_BITS-1:0]),
      .wr_data (sym),
      .rd_addr (i_ff[IDX_BITS-1:0]),
      .rd_data (a_rd)
   );

   ede_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_ram_b (
      .clock   (clock),
      .wr_en   (append_b && !full_b),
      .wr_addr (len_b_ff[IDX_BITS-1:0]),
      .wr_data (sym),
      .rd_addr (j_minus_one[IDX_BITS-1:0]),
      .rd_data (b_rd)
   );

   ede_ram #(.WIDTH(LEN_BITS), .DEPTH(MAX_LEN + 1)) u_ram_cost (
      .clock   (clock),
      .wr_en   (cost_wr_en),
      .wr_addr (cost_wr_addr),
      .wr_data (cost_wr_data),
      .rd_addr (cost_rd_addr),
      .rd_data (cost_rd)
   );

   // one cell of the recurrence: above comes from the row, left and diagonal are held
   assign min_da     = (diag_ff < cost_rd) ? diag_ff : cost_rd;
   assign min_all    = (min_da < left_ff) ? min_da : left_ff;
   assign cell_value = (a_sym_ff == b_rd) ? diag_ff : (min_all + LEN_BITS'(1));

   always_comb begin
      cost_wr_en   = 1'b0;
      cost_wr_addr = j_ff;
      cost_wr_data = j_ff;
      case (ctrl.cost_wr)
         COST_WR_NONE: begin
            cost_wr_en = 1'b0;
         end
         COST_WR_J: begin
            cost_wr_en = 1'b1;
         end
         COST_WR_ROW: begin
            cost_wr_en   = 1'b1;
            cost_wr_addr = '0;
            cost_wr_data = i_plus_one;
         end
         COST_WR_CELL: begin
            cost_wr_en   = 1'b1;
            cost_wr_data = cell_value;
         end
         default: begin
            cost_wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (ctrl.cost_rd)
         COST_RD_ZERO: cost_rd_addr = '0;
         COST_RD_J:    cost_rd_addr = j_ff;
         COST_RD_LB:   cost_rd_addr = len_b_ff;
         default:      cost_rd_addr = '0;
      endcase
   end

   always_comb begin
      case (ctrl.j_op)
         J_HOLD:  j_in = j_ff;
         J_ZERO:  j_in = '0;
         J_ONE:   j_in = LEN_BITS'(1);
         J_INC:   j_in = j_ff + LEN_BITS'(1);
         default: j_in = j_ff;
      endcase
      case (ctrl.i_op)
         I_HOLD:  i_in = i_ff;
         I_ZERO:  i_in = '0;
         I_INC:   i_in = i_plus_one;
         default: i_in = i_ff;
      endcase
   end

   always_comb begin
      diag_in  = diag_ff;
      left_in  = left_ff;
      a_sym_in = a_sym_ff;
      if (ctrl.row_load) begin
         diag_in  = cost_rd;
         left_in  = i_plus_one;
         a_sym_in = a_rd;
      end else if (ctrl.calc) begin
         diag_in = cost_rd;
         left_in = cell_value;
      end
   end

   always_comb begin
      len_a_in = len_a_ff;
      len_b_in = len_b_ff;
      ovf_in   = ovf_ff;
      if (ctrl.emit) begin
         len_a_in = '0;
         len_b_in = '0;
         ovf_in   = 1'b0;
      end else begin
         if (append_a) begin
            if (full_a) begin
               ovf_in = 1'b1;
            end else begin
               len_a_in = len_a_ff + LEN_BITS'(1);
            end
         end
         if (append_b) begin
            if (full_b) begin
               ovf_in = 1'b1;
            end else begin
               len_b_in = len_b_ff + LEN_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff <= '0;
         len_b_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         len_a_ff <= len_a_in;
         len_b_ff <= len_b_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      diag_ff  <= diag_in;
      left_ff  <= left_in;
      a_sym_ff <= a_sym_in;
   end

   assign cond.i_end   = (i_ff == len_a_ff);
   assign cond.j_end   = (j_ff == len_b_ff);
   assign cond.lb_zero = (len_b_ff == '0);

   assign rsp_distance = DIST_BITS'(cost_rd);
   assign rsp_overflow = ovf_ff;

endmodule
